// ===== hdl/stie_pkg.sv =====
// Shared types, codes and small arithmetic helpers of the stimulation envelope.
`default_nettype none
package stie_pkg;

    // Envelope phases
    typedef logic [1:0] t_phase;
    localparam t_phase PH_OVER = 2'd0;
    localparam t_phase PH_RISE = 2'd1;
    localparam t_phase PH_HOLD = 2'd2;
    localparam t_phase PH_FALL = 2'd3;

    // Request kinds
    typedef logic [2:0] t_action;
    localparam t_action ACT_SECOND = 3'd0;
    localparam t_action ACT_TICK   = 3'd1;
    localparam t_action ACT_SET    = 3'd2;
    localparam t_action ACT_START  = 3'd3;
    localparam t_action ACT_STOP   = 3'd4;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_RISE  = 2'd0;
    localparam t_cfg_idx CFG_FALL  = 2'd1;
    localparam t_cfg_idx CFG_HOLD  = 2'd2;
    localparam t_cfg_idx CFG_START = 2'd3;

    localparam logic [6:0] FROZEN_HOLD = 7'd99;
    localparam logic [6:0] MAX_COUNT   = 7'd127;
    localparam logic [7:0] HUNDRED     = 8'd100;

    typedef struct packed {
        logic [6:0] rise_time;
        logic [6:0] fall_time;
        logic [6:0] hold_seconds;
        logic       start_at_one;
    } t_cfg;

    typedef struct packed {
        t_action    action;
        logic [7:0] intensity_value;
        logic       electrode_off;
    } t_item;

    typedef struct packed {
        logic       ramp_busy;
        logic       start_refused;
        t_phase     phase;
        logic [7:0] level;
    } t_result;

    // Multiply a level by one hundred with shifts and adds
    function automatic logic [15:0] mul100(input logic [7:0] d);
        logic [15:0] x;
        begin
            x = {8'd0, d};
            mul100 = (x << 6) + (x << 5) + (x << 2);
        end
    endfunction

    // Countdown reload: hold plus rise/10, saturated to seven bits
    function automatic logic [6:0] reload_value(input logic [6:0] hold,
                                                input logic [6:0] rise);
        logic [14:0] prod;
        logic [7:0]  sum;
        begin
            prod = {8'd0, rise} * 15'd205;
            sum  = {1'b0, hold} + {4'd0, prod[14:11]};
            reload_value = (sum > {1'b0, MAX_COUNT}) ? MAX_COUNT : sum[6:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/stie_div.sv =====
// Serial restoring divider: 16-bit dividend by 8-bit divisor, one bit a cycle.
`default_nettype none
module stie_div
    import stie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_num,
    input  wire logic [7:0]  i_den,
    output logic             o_done,
    output logic [15:0]      o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [7:0]  r_rem;
    logic [15:0] r_quo;
    logic [7:0]  r_den;
    logic [8:0]  w_shift;
    logic        w_ge;
    logic [8:0]  w_diff;

    // Trial subtract of the shifted remainder
    always_comb begin
        w_shift = {r_rem, r_quo[15]};
        w_ge    = (w_shift >= {1'b0, r_den});
        w_diff  = w_shift - {1'b0, r_den};
    end

    // Control: load on start, count sixteen steps, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[14:0], w_ge};
            r_rem <= w_ge ? w_diff[7:0] : w_shift[7:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// ===== hdl/stie_core.sv =====
// Envelope sequencer: applies one request, runs the main-loop rule, drives the divider.
`default_nettype none
module stie_core
    import stie_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_start,
    input  wire t_item   i_item,
    output logic         o_ready,
    output logic         o_done,
    input  wire logic    i_ack,
    output t_result      o_result
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACT  = 6'b000010,
        S_TDIV = 6'b000100,
        S_RULE = 6'b001000,
        S_RDIV = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_item       r_item;
    logic [7:0]  r_target, n_target;
    logic [7:0]  r_level, n_level;
    logic [15:0] r_lh, n_lh;
    logic [15:0] r_inc, n_inc;
    logic [7:0]  r_ticks, n_ticks;
    t_phase      r_phase, n_phase;
    logic [6:0]  r_secs, n_secs;
    t_phase      r_prev_phase, n_prev_phase;
    logic [7:0]  r_prev_int, n_prev_int;
    logic        r_refresh, n_refresh;
    logic        r_busy, n_busy;
    logic        r_refused, n_refused;

    logic        w_div_start;
    logic [15:0] w_div_num;
    logic [7:0]  w_div_den;
    logic        w_div_done;
    logic [15:0] w_div_quo;

    logic [7:0]  w_rise2;
    logic [7:0]  w_fall2;
    logic [7:0]  w_base;
    logic [6:0]  w_reload;
    logic [7:0]  w_ticks_inc;
    logic [16:0] w_sum;
    t_phase      w_ph;
    logic        w_changed;
    logic        w_scale;
    logic [7:0]  w_lo;
    logic [7:0]  w_den;

    stie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Derived values shared by several steps
    always_comb begin
        w_rise2     = {i_cfg.rise_time, 1'b0};
        w_fall2     = {i_cfg.fall_time, 1'b0};
        w_base      = i_cfg.start_at_one ? 8'd1 : 8'((({1'b0, r_target}) + 9'd1) >> 1);
        w_reload    = reload_value(i_cfg.hold_seconds, i_cfg.rise_time);
        w_ticks_inc = r_ticks + 8'd1;
        w_sum       = {1'b0, r_lh} + {1'b0, r_inc};
        w_ph        = ((r_secs == 7'd0) && (r_phase != PH_OVER)) ? PH_FALL : r_phase;
        w_changed   = (r_prev_phase != w_ph) || r_refresh;
    end

    // Sequencer and envelope state update
    always_comb begin
        n_state      = r_state;
        n_target     = r_target;
        n_level      = r_level;
        n_lh         = r_lh;
        n_inc        = r_inc;
        n_ticks      = r_ticks;
        n_phase      = r_phase;
        n_secs       = r_secs;
        n_prev_phase = r_prev_phase;
        n_prev_int   = r_prev_int;
        n_refresh    = r_refresh;
        n_busy       = r_busy;
        n_refused    = r_refused;
        w_div_start  = 1'b0;
        w_div_num    = '0;
        w_div_den    = HUNDRED;
        w_scale      = 1'b0;
        w_lo         = w_base;
        w_den        = w_rise2;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state   = S_ACT;
                    n_refused = 1'b0;
                end
            end

            // Apply the request itself
            S_ACT: begin
                n_state = S_RULE;
                unique case (r_item.action)
                    ACT_SECOND: begin
                        if ((r_secs != 7'd0) && (i_cfg.hold_seconds != FROZEN_HOLD)) begin
                            n_secs = r_secs - 7'd1;
                        end
                    end
                    ACT_TICK: begin
                        if (r_busy && (r_phase == PH_RISE)) begin
                            n_ticks = (w_ticks_inc > w_rise2) ? w_rise2 : w_ticks_inc;
                            if (r_level >= r_target) begin
                                n_level = r_target;
                                n_busy  = 1'b0;
                                n_ticks = w_rise2;
                                n_phase = PH_HOLD;
                            end else begin
                                n_lh        = w_sum[16] ? 16'hFFFF : w_sum[15:0];
                                w_div_start = 1'b1;
                                w_div_num   = n_lh;
                                n_state     = S_TDIV;
                            end
                        end else if (r_busy && (r_phase == PH_FALL)) begin
                            n_ticks = '0;
                            if (r_level <= w_base) begin
                                n_level = '0;
                                n_busy  = 1'b0;
                                n_lh    = '0;
                                n_phase = PH_OVER;
                            end else begin
                                n_lh        = (r_lh >= r_inc) ? (r_lh - r_inc) : 16'd0;
                                w_div_start = 1'b1;
                                w_div_num   = n_lh;
                                n_state     = S_TDIV;
                            end
                        end
                    end
                    ACT_SET: begin
                        n_target  = r_item.intensity_value;
                        if (r_phase == PH_HOLD) n_level = r_item.intensity_value;
                        n_refresh = 1'b1;
                        n_busy    = 1'b1;
                        n_secs    = w_reload;
                    end
                    ACT_START: begin
                        if (r_item.electrode_off || (r_target == 8'd0)) begin
                            n_refused = 1'b1;
                        end else begin
                            if (r_phase != PH_HOLD) n_phase = PH_RISE;
                            n_secs = w_reload;
                        end
                    end
                    ACT_STOP: begin
                        n_secs = '0;
                    end
                    default: begin
                    end
                endcase
            end

            // Level from the accumulator, saturated to eight bits
            S_TDIV: begin
                if (w_div_done) begin
                    n_level = (w_div_quo[15:8] != 8'd0) ? 8'hFF : w_div_quo[7:0];
                    n_state = S_RULE;
                end
            end

            // Main-loop rule: forced fall, then increment refresh
            S_RULE: begin
                n_state = S_DONE;
                n_phase = w_ph;
                if (w_changed) begin
                    n_busy = 1'b1;
                    if (w_ph == PH_RISE) begin
                        if (i_cfg.rise_time == 7'd0) begin
                            n_level = r_target;
                        end else if ((r_prev_int == r_target) || (r_prev_int == 8'd0)) begin
                            n_level = w_base;
                            n_lh    = mul100(w_base);
                            w_scale = 1'b1;
                        end else if (w_rise2 > r_ticks) begin
                            w_lo    = r_level;
                            w_den   = w_rise2 - r_ticks;
                            w_scale = 1'b1;
                        end
                    end else if (w_ph == PH_FALL) begin
                        if (i_cfg.fall_time == 7'd0) begin
                            n_level = '0;
                        end else begin
                            if (w_rise2 == r_ticks) n_lh = mul100(r_target);
                            w_den   = w_fall2;
                            w_scale = 1'b1;
                        end
                    end
                end
                if (w_scale) begin
                    if (r_target <= w_lo) begin
                        n_inc = '0;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_num   = mul100(r_target - w_lo);
                        w_div_den   = w_den;
                        n_state     = S_RDIV;
                    end
                end
                n_prev_phase = w_ph;
                n_prev_int   = r_target;
                n_refresh    = 1'b0;
            end

            // Hold the new increment
            S_RDIV: begin
                if (w_div_done) begin
                    n_inc   = w_div_quo;
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_ack) n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and envelope registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_target     <= 8'd10;
            r_level      <= '0;
            r_lh         <= '0;
            r_inc        <= '0;
            r_ticks      <= '0;
            r_phase      <= PH_OVER;
            r_secs       <= 7'd5;
            r_prev_phase <= PH_OVER;
            r_prev_int   <= '0;
            r_refresh    <= 1'b0;
            r_busy       <= 1'b0;
            r_refused    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_target     <= n_target;
            r_level      <= n_level;
            r_lh         <= n_lh;
            r_inc        <= n_inc;
            r_ticks      <= n_ticks;
            r_phase      <= n_phase;
            r_secs       <= n_secs;
            r_prev_phase <= n_prev_phase;
            r_prev_int   <= n_prev_int;
            r_refresh    <= n_refresh;
            r_busy       <= n_busy;
            r_refused    <= n_refused;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == S_IDLE)) r_item <= i_item;
    end

    assign o_ready                = (r_state == S_IDLE);
    assign o_done                 = (r_state == S_DONE);
    assign o_result.level         = r_level;
    assign o_result.phase         = r_phase;
    assign o_result.start_refused = r_refused;
    assign o_result.ramp_busy     = r_busy;

endmodule
`default_nettype wire

// ===== hdl/stim_intensity_envelope.sv =====
// Top level of the stimulation envelope: stream ports, settings and result register.
//
//  Channel  Dir  Handshake                     Payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: intensity, electrode off; tuser: action
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: level, phase, refused, busy
//  cfg      in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// A request runs through the sequencer, with up to two divisions on the shared
// serial divider (accumulator scaling on a ramp tick, increment on a refresh).
// Reset is synchronous and active low and restores all settings and the
// envelope state. The result sits in an output register, so the next
// request is taken while it waits; a full register holds the sequencer
// until the downstream side takes it.
`default_nettype none
module stim_intensity_envelope
    import stie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] intensity_value, [8] electrode_off
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] level, [9:8] phase,
                                             // [10] start_refused, [11] ramp_busy
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_core_ready;
    logic    w_core_done;
    logic    w_load;

    // Settings registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise_time    <= 7'd10;
            r_cfg.fall_time    <= 7'd10;
            r_cfg.hold_seconds <= 7'd5;
            r_cfg.start_at_one <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RISE:  r_cfg.rise_time    <= i_cfg_data;
                CFG_FALL:  r_cfg.fall_time    <= i_cfg_data;
                CFG_HOLD:  r_cfg.hold_seconds <= i_cfg_data;
                CFG_START: r_cfg.start_at_one <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Unpack the request
    assign w_item.action          = s_axis_tuser;
    assign w_item.intensity_value = s_axis_tdata[7:0];
    assign w_item.electrode_off   = s_axis_tdata[8];

    stie_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (s_axis_tvalid),
        .i_item   (w_item),
        .o_ready  (w_core_ready),
        .o_done   (w_core_done),
        .i_ack    (w_load),
        .o_result (w_result)
    );

    assign s_axis_tready = w_core_ready;

    // Result register: load when empty or being drained
    assign w_load = w_core_done && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_out <= w_result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.ramp_busy, r_out.start_refused, r_out.phase,
                            r_out.level};

endmodule
`default_nettype wire
